[sv/tpd_pkg.sv]
// Package for the turning point detector.
// Holds default widths, point kind codes, slope direction codes and queue sizing.
// No dependencies.
package tpd_pkg;

    localparam int TIME_BITS_DEF  = 32;
    localparam int VALUE_BITS_DEF = 32;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_PTR_BITS = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_BITS = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [1:0] {
        KIND_FIRST  = 2'd0,
        KIND_PEAK   = 2'd1,
        KIND_VALLEY = 2'd2,
        KIND_FINAL  = 2'd3
    } kind_t;

    typedef enum logic [2:0] {
        DIR_NONE = 3'b001,
        DIR_UP   = 3'b010,
        DIR_DOWN = 3'b100
    } dir_t;

endpackage

[sv/tpd_sample_if.sv]
// Sample channel of the turning point detector: valid/ready plus one sample word.
// Depends on tpd_pkg for default widths.
interface tpd_sample_if #(
    parameter int TIME_BITS  = tpd_pkg::TIME_BITS_DEF,
    parameter int VALUE_BITS = tpd_pkg::VALUE_BITS_DEF
);
    logic                         valid;
    logic                         ready;
    logic        [TIME_BITS-1:0]  sample_time;
    logic signed [VALUE_BITS-1:0] sample_value;
    logic                         series_end;

    modport source (output valid, output sample_time, output sample_value,
                    output series_end, input ready);
    modport sink   (input valid, input sample_time, input sample_value,
                    input series_end, output ready);
endinterface

[sv/tpd_point_if.sv]
// Point channel of the turning point detector: valid/ready plus one point word.
// Depends on tpd_pkg for default widths and the point kind type.
interface tpd_point_if #(
    parameter int TIME_BITS  = tpd_pkg::TIME_BITS_DEF,
    parameter int VALUE_BITS = tpd_pkg::VALUE_BITS_DEF
);
    logic                         valid;
    logic                         ready;
    logic        [TIME_BITS-1:0]  point_time;
    logic signed [VALUE_BITS-1:0] point_value;
    tpd_pkg::kind_t               point_kind;
    logic                         run_last;

    modport source (output valid, output point_time, output point_value,
                    output point_kind, output run_last, input ready);
    modport sink   (input valid, input point_time, input point_value,
                    input point_kind, input run_last, output ready);
endinterface

[sv/turning_point_detector.sv]
// Turning point detector top level: slope tracking and a small result queue.
// Depends on tpd_pkg, tpd_sample_if and tpd_point_if.

// Takes one sample word per cycle and emits first, peak, valley and final points
// of each series. A sample word is accepted whenever the point queue has room for
// two words; it is evaluated in the accept cycle against the previous sample and
// its points are written into a four-entry queue, so the first point can appear on
// the next cycle. Throughput is one sample per cycle while each sample yields at
// most one point and the point queue is not held up by points.ready; a sample
// that closes a series on a reversal yields two points, which leave in turn through
// the single point port. run_last marks the final point caused by a sample.
module turning_point_detector #(
    parameter int TIME_BITS  = tpd_pkg::TIME_BITS_DEF,
    parameter int VALUE_BITS = tpd_pkg::VALUE_BITS_DEF
) (
    input  logic clk,
    input  logic rst_n,
    tpd_sample_if.sink  samples,
    tpd_point_if.source points
);

    localparam int PTR_BITS = tpd_pkg::QUEUE_PTR_BITS;
    localparam int CNT_BITS = tpd_pkg::QUEUE_CNT_BITS;

    typedef struct packed {
        logic        [TIME_BITS-1:0]  ptime;
        logic signed [VALUE_BITS-1:0] pvalue;
        tpd_pkg::kind_t               kind;
        logic                         last;
    } entry_t;

    logic                         started_reg, started_next;
    tpd_pkg::dir_t                dir_reg, dir_next;
    logic        [TIME_BITS-1:0]  prior_time_reg;
    logic signed [VALUE_BITS-1:0] prior_value_reg;

    entry_t                queue_reg [tpd_pkg::QUEUE_DEPTH];
    logic [PTR_BITS-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_BITS-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_BITS-1:0]   count_reg, count_next;

    logic   accept;
    logic   pop;
    logic   rise;
    logic   fall;
    logic   have_a;
    logic   have_b;
    entry_t res_a;
    entry_t res_b;
    logic [PTR_BITS-1:0] wr_ptr_b;
    logic [CNT_BITS-1:0] push_cnt;

    assign samples.ready = (count_reg <= CNT_BITS'(tpd_pkg::QUEUE_DEPTH - 2));
    assign accept = samples.valid && samples.ready;
    assign pop    = points.valid && points.ready;

    assign rise = samples.sample_value > prior_value_reg;
    assign fall = samples.sample_value < prior_value_reg;

    always_comb
    begin
        started_next = started_reg;
        dir_next     = dir_reg;
        have_a       = 1'b0;
        have_b       = 1'b0;
        res_a.ptime  = prior_time_reg;
        res_a.pvalue = prior_value_reg;
        res_a.kind   = tpd_pkg::KIND_PEAK;
        res_a.last   = 1'b1;
        res_b.ptime  = samples.sample_time;
        res_b.pvalue = samples.sample_value;
        res_b.kind   = tpd_pkg::KIND_FINAL;
        res_b.last   = 1'b1;

        if (!started_reg)
        begin
            have_a       = 1'b1;
            res_a.ptime  = samples.sample_time;
            res_a.pvalue = samples.sample_value;
            res_a.kind   = tpd_pkg::KIND_FIRST;
            started_next = 1'b1;
            dir_next     = tpd_pkg::DIR_NONE;
        end
        else
        begin
            unique case (dir_reg)
                tpd_pkg::DIR_UP:
                begin
                    if (fall)
                    begin
                        have_a   = 1'b1;
                        dir_next = tpd_pkg::DIR_DOWN;
                    end
                end
                tpd_pkg::DIR_DOWN:
                begin
                    if (rise)
                    begin
                        have_a     = 1'b1;
                        res_a.kind = tpd_pkg::KIND_VALLEY;
                        dir_next   = tpd_pkg::DIR_UP;
                    end
                end
                default:
                begin
                    if (rise)
                        dir_next = tpd_pkg::DIR_UP;
                    else if (fall)
                        dir_next = tpd_pkg::DIR_DOWN;
                end
            endcase
            have_b     = samples.series_end && (dir_next != tpd_pkg::DIR_NONE);
            res_a.last = !have_b;
        end

        if (samples.series_end)
        begin
            started_next = 1'b0;
            dir_next     = tpd_pkg::DIR_NONE;
        end
    end

    assign wr_ptr_b = wr_ptr_reg + PTR_BITS'(have_a);
    assign push_cnt = accept ? (CNT_BITS'(have_a) + CNT_BITS'(have_b)) : '0;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + PTR_BITS'(push_cnt);
        rd_ptr_next = rd_ptr_reg + PTR_BITS'(pop);
        count_next  = count_reg + push_cnt - CNT_BITS'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            started_reg     <= 1'b0;
            dir_reg         <= tpd_pkg::DIR_NONE;
            prior_time_reg  <= '0;
            prior_value_reg <= '0;
            wr_ptr_reg      <= '0;
            rd_ptr_reg      <= '0;
            count_reg       <= '0;
        end
        else
        begin
            if (accept)
            begin
                started_reg     <= started_next;
                dir_reg         <= dir_next;
                prior_time_reg  <= samples.sample_time;
                prior_value_reg <= samples.sample_value;
            end
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && have_a)
            queue_reg[wr_ptr_reg] <= res_a;
        if (accept && have_b)
            queue_reg[wr_ptr_b] <= res_b;
    end

    assign points.valid       = (count_reg != '0);
    assign points.point_time  = queue_reg[rd_ptr_reg].ptime;
    assign points.point_value = queue_reg[rd_ptr_reg].pvalue;
    assign points.point_kind  = queue_reg[rd_ptr_reg].kind;
    assign points.run_last    = queue_reg[rd_ptr_reg].last;

endmodule

[sim/turning_point_detector_test.sv]
// Testbench for turning_point_detector: random and directed sample series with an
// in-order predictor of first, peak, valley and final points; checks every point word.
// Depends on tpd_pkg, tpd_sample_if, tpd_point_if and turning_point_detector.
module turning_point_detector_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int TIME_W  = tpd_pkg::TIME_BITS_DEF;
    localparam int VALUE_W = tpd_pkg::VALUE_BITS_DEF;
    localparam logic signed [VALUE_W-1:0] VALUE_MAX = {1'b0, {(VALUE_W-1){1'b1}}};
    localparam logic signed [VALUE_W-1:0] VALUE_MIN = {1'b1, {(VALUE_W-1){1'b0}}};
    localparam int ITEMS_PER_PHASE = 210;
    localparam int HOLD_CYCLES     = 60;
    localparam int DRAIN_CYCLES    = 20;

    typedef struct packed {
        logic        [TIME_W-1:0]  stamp;
        logic signed [VALUE_W-1:0] value;
        logic                      ends;
    } sample_word_t;

    typedef struct packed {
        logic        [TIME_W-1:0]  stamp;
        logic signed [VALUE_W-1:0] value;
        tpd_pkg::kind_t            kind;
        logic                      run_last;
    } point_word_t;

    logic clk = 1'b0;
    logic rst_n;

    tpd_sample_if samples_ch ();
    tpd_point_if  points_ch ();

    turning_point_detector dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .samples (samples_ch),
        .points  (points_ch)
    );

    always #5 clk = ~clk;

    sample_word_t pending_samples[$];
    point_word_t  expected_points[$];

    int tx_idle_pct;
    int rx_idle_pct;
    int hold_requests;
    int holds_served;
    int hold_left;
    int fail_count;

    // predictor state
    logic                      series_open;
    tpd_pkg::dir_t             slope;
    logic        [TIME_W-1:0]  prev_stamp;
    logic signed [VALUE_W-1:0] prev_value;

    task automatic log_failure(input string msg);
        fail_count++;
        if (fail_count <= 10)
            $display("%s", msg);
    endtask

    task automatic predict_points(input logic [TIME_W-1:0] stamp,
                                  input logic signed [VALUE_W-1:0] value,
                                  input logic ends);
        point_word_t pts[$];
        if (!series_open) begin
            pts.push_back('{stamp, value, tpd_pkg::KIND_FIRST, 1'b0});
            series_open = 1'b1;
            slope = tpd_pkg::DIR_NONE;
        end
        else begin
            case (slope)
                tpd_pkg::DIR_UP:
                begin
                    if (value < prev_value)
                    begin
                        pts.push_back('{prev_stamp, prev_value, tpd_pkg::KIND_PEAK, 1'b0});
                        slope = tpd_pkg::DIR_DOWN;
                    end
                end
                tpd_pkg::DIR_DOWN:
                begin
                    if (value > prev_value)
                    begin
                        pts.push_back('{prev_stamp, prev_value, tpd_pkg::KIND_VALLEY, 1'b0});
                        slope = tpd_pkg::DIR_UP;
                    end
                end
                default:
                begin
                    if (value > prev_value)
                        slope = tpd_pkg::DIR_UP;
                    else if (value < prev_value)
                        slope = tpd_pkg::DIR_DOWN;
                end
            endcase
            if (ends && slope != tpd_pkg::DIR_NONE)
                pts.push_back('{stamp, value, tpd_pkg::KIND_FINAL, 1'b0});
        end
        prev_stamp = stamp;
        prev_value = value;
        if (ends)
        begin
            series_open = 1'b0;
            slope = tpd_pkg::DIR_NONE;
        end
        if (pts.size() > 0)
            pts[pts.size()-1].run_last = 1'b1;
        foreach (pts[i])
            expected_points.push_back(pts[i]);
    endtask

    // sample driver
    always @(posedge clk or negedge rst_n)
    begin : sample_driver
        sample_word_t word;
        if (!rst_n)
        begin
            samples_ch.valid <= 1'b0;
        end
        else
        begin
            if (samples_ch.valid && samples_ch.ready)
                predict_points(samples_ch.sample_time, samples_ch.sample_value,
                               samples_ch.series_end);
            if (!samples_ch.valid || samples_ch.ready)
            begin
                if (pending_samples.size() != 0 && $urandom_range(99) >= tx_idle_pct)
                begin
                    word = pending_samples.pop_front();
                    samples_ch.valid        <= 1'b1;
                    samples_ch.sample_time  <= word.stamp;
                    samples_ch.sample_value <= word.value;
                    samples_ch.series_end   <= word.ends;
                end
                else
                begin
                    samples_ch.valid <= 1'b0;
                end
            end
        end
    end

    // point monitor and receiver
    always @(posedge clk or negedge rst_n)
    begin : point_monitor
        point_word_t got;
        point_word_t want;
        if (!rst_n)
        begin
            points_ch.ready <= 1'b0;
            hold_left = 0;
            holds_served = 0;
        end
        else
        begin
            if (points_ch.valid && points_ch.ready)
            begin
                got = '{points_ch.point_time, points_ch.point_value,
                        points_ch.point_kind, points_ch.run_last};
                if (expected_points.size() == 0)
                begin
                    log_failure($sformatf("unexpected point word: t=%h v=%h kind=%0d last=%b",
                                          got.stamp, got.value, got.kind, got.run_last));
                end
                else
                begin
                    want = expected_points.pop_front();
                    if (got.stamp !== want.stamp || got.value !== want.value ||
                        got.kind !== want.kind || got.run_last !== want.run_last)
                        log_failure($sformatf({"point mismatch: ",
                            "expected t=%h v=%h kind=%0d last=%b, ",
                            "got t=%h v=%h kind=%0d last=%b"},
                            want.stamp, want.value, want.kind, want.run_last,
                            got.stamp, got.value, got.kind, got.run_last));
                end
            end
            if (hold_left > 0)
            begin
                hold_left = hold_left - 1;
                points_ch.ready <= 1'b0;
            end
            else if (holds_served != hold_requests)
            begin
                holds_served = holds_served + 1;
                hold_left = HOLD_CYCLES;
                points_ch.ready <= 1'b0;
            end
            else
            begin
                points_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
            end
        end
    end

    task automatic queue_sample(input logic [TIME_W-1:0] stamp,
                                input logic signed [VALUE_W-1:0] value,
                                input logic ends);
        sample_word_t w;
        w.stamp = stamp;
        w.value = value;
        w.ends  = ends;
        pending_samples.push_back(w);
    endtask

    task automatic queue_series(input int length);
        logic        [TIME_W-1:0]  stamp;
        logic signed [VALUE_W-1:0] value;
        stamp = $urandom;
        value = ($urandom_range(7) == 0) ? VALUE_MIN : $urandom;
        for (int i = 0; i < length; i++)
        begin
            queue_sample(stamp, value, i == length - 1);
            stamp = stamp + $urandom_range(1, 100);
            case ($urandom_range(9))
                0, 1: ;
                2, 3, 4: value = value + int'($urandom_range(1, 300));
                5, 6, 7: value = value - int'($urandom_range(1, 300));
                8: value = $urandom;
                default: value = $urandom_range(1) ? VALUE_MAX : VALUE_MIN;
            endcase
        end
    endtask

    // broken sequences: random words with random end marks
    task automatic queue_noise(input int length);
        logic signed [VALUE_W-1:0] value;
        value = $urandom;
        for (int i = 0; i < length; i++)
        begin
            if ($urandom_range(2) != 0)
                value = $urandom;
            queue_sample($urandom, value, 1'($urandom_range(1)));
        end
    endtask

    task automatic queue_random_phase(input int target);
        int count;
        int length;
        count = 0;
        while (count < target)
        begin
            if ($urandom_range(9) == 0)
            begin
                length = $urandom_range(1, 4);
                queue_noise(length);
            end
            else
            begin
                length = ($urandom_range(5) == 0) ? $urandom_range(1, 2)
                                                  : $urandom_range(3, 14);
                queue_series(length);
            end
            count += length;
        end
    endtask

    task automatic wait_drained();
        while (pending_samples.size() != 0 || samples_ch.valid ||
               expected_points.size() != 0)
            @(negedge clk);
    endtask

    initial
    begin
        rst_n = 1'b0;
        samples_ch.valid = 1'b0;
        samples_ch.sample_time = '0;
        samples_ch.sample_value = '0;
        samples_ch.series_end = 1'b0;
        points_ch.ready = 1'b0;
        series_open = 1'b0;
        slope = tpd_pkg::DIR_NONE;
        prev_stamp = '0;
        prev_value = '0;
        fail_count = 0;
        hold_requests = 0;
        tx_idle_pct = 28;
        rx_idle_pct = 59;

        // single-sample series
        queue_sample(32'd0, 32'sd0, 1'b1);
        // two samples, different values
        queue_sample(32'd1, 32'sd100, 1'b0);
        queue_sample(32'd2, 32'sd200, 1'b1);
        // constant series
        queue_sample(32'd3, 32'sd50, 1'b0);
        queue_sample(32'd4, 32'sd50, 1'b0);
        queue_sample(32'd5, 32'sd50, 1'b1);
        // extremes, flats before reversals, reversal on the final sample
        queue_sample(32'hFFFF_FFFF, VALUE_MAX, 1'b0);
        queue_sample(32'd0, VALUE_MAX, 1'b0);
        queue_sample(32'd10, VALUE_MIN, 1'b0);
        queue_sample(32'd11, VALUE_MIN, 1'b0);
        queue_sample(32'd12, VALUE_MAX, 1'b0);
        queue_sample(32'd13, -32'sd1, 1'b0);
        queue_sample(32'd14, 32'sd0, 1'b0);
        queue_sample(32'd15, -32'sd65536, 1'b1);
        // valley detected by the final sample
        queue_sample(32'd20, -32'sd5, 1'b0);
        queue_sample(32'd21, -32'sd5, 1'b0);
        queue_sample(32'd22, -32'sd7, 1'b0);
        queue_sample(32'd23, -32'sd3, 1'b1);
        // rise then flat to the end
        queue_sample(32'd30, 32'sd0, 1'b0);
        queue_sample(32'd31, 32'sd1, 1'b0);
        queue_sample(32'd32, 32'sd1, 1'b0);
        queue_sample(32'd33, 32'sd1, 1'b1);

        queue_random_phase(ITEMS_PER_PHASE);

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        @(negedge clk);
        hold_requests = hold_requests + 1;
        wait_drained();

        tx_idle_pct = 59;
        rx_idle_pct = 28;
        queue_random_phase(ITEMS_PER_PHASE);
        wait_drained();

        tx_idle_pct = 0;
        rx_idle_pct = 0;
        queue_random_phase(ITEMS_PER_PHASE);
        repeat (5) @(negedge clk);
        hold_requests = hold_requests + 1;
        wait_drained();

        repeat (DRAIN_CYCLES) @(negedge clk);
        if (fail_count == 0 && expected_points.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    initial
    begin
        #2_000_000;
        $display("Verification failed");
        $finish;
    end

endmodule

[turning_point_detector.f]
sv/tpd_pkg.sv
sv/tpd_sample_if.sv
sv/tpd_point_if.sv
sv/turning_point_detector.sv
sim/turning_point_detector_test.sv
